// ----- src/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// shared sizes, codes and types of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int POOL_BYTES   = 256;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 16;

    localparam int REQ_W  = 9;
    localparam int REL_W  = 8;
    localparam int GNT_W  = 8;
    localparam int ST_W   = 2;

    localparam int OFF_W  = $clog2(POOL_BYTES);
    localparam int LEN_W  = $clog2(POOL_BYTES);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    // arithmetic width for offset and length sums and differences
    localparam int WIDE_W = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;

    localparam int S_TDATA_W = ((REQ_W + REL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ST_W + GNT_W + 7) / 8) * 8;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_INVALID      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             taken;
    } t_entry;

endpackage

// ----- src/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over a fixed byte pool with split and coalescing
// ----------------------------------------------------------------------------
// The block table (header offset, data length, taken flag per block) lives
// in one synchronous memory of MAX_BLOCKS entries with one write port and a
// separate registered read port. After reset the S_INIT state writes the
// initial block before the first request is taken. Each request walks the
// table from entry 0, reading and then checking each entry it visits. An
// allocate that splits then moves the entries behind the hit up by one, a
// read and a write per moved entry, and then writes the free remainder and
// the taken block. A free then reads each neighbor and, on every merge,
// moves the later entries down by one, a read and a write per moved entry.
// The longest request is a free that merges with both neighbors near the
// front of a full table. The result sits in an output register, so the next
// request is taken while a result waits on the master side.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side request
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: request_bytes[8:0], release_offset[16:9], zero pad
    input  logic [ffba_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: operation[0]
    input  logic                           i_s_axis_tuser,
    // master side result
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: status[1:0], granted_offset[9:2], zero pad
    output logic [ffba_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CK, S_SHIFT_RD, S_SHIFT_WR,
        S_INSERT, S_TAKE_WR, S_CHK_NX, S_NX_CK, S_CHK_PV, S_PV_CK,
        S_DROP_RD, S_DROP_WR, S_FINAL_WR, S_RESULT
    } t_state;

    // block table memory
    t_entry             r_mem [MAX_BLOCKS];
    t_entry             r_q;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [IDX_W-1:0]   w_raddr;
    t_entry             w_wdata;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_k, n_k;
    t_entry             r_cur, n_cur;
    t_op                r_op, n_op;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [REL_W-1:0]   r_rel, n_rel;
    t_status            r_res_st, n_res_st;
    logic [GNT_W-1:0]   r_res_gr, n_res_gr;
    logic               r_ov, n_ov;
    logic [M_TDATA_W-1:0] r_odata, n_odata;

    // arithmetic on the entry just read
    logic [WIDE_W-1:0]  w_len;
    logic [WIDE_W-1:0]  w_reqw;
    logic [WIDE_W-1:0]  w_rest;
    logic [WIDE_W-1:0]  w_data_off;
    logic               w_fit;
    logic               w_hit_off;
    logic               w_split;
    logic               w_more;

    always_comb begin
        w_len      = WIDE_W'(r_q.length);
        w_reqw     = WIDE_W'(r_req);
        w_rest     = w_len - w_reqw;
        w_data_off = WIDE_W'(r_q.offset) + WIDE_W'(HEADER_BYTES);
        w_fit      = !r_q.taken && (w_len >= w_reqw);
        w_hit_off  = (w_data_off == WIDE_W'(r_rel));
        w_split    = (w_rest >= WIDE_W'(HEADER_BYTES)) &&
                     (r_count < CNT_W'(MAX_BLOCKS));
        // another valid entry after the current index
        w_more     = (CNT_W'(r_idx) + CNT_W'(1)) < r_count;
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_count  = r_count;
        n_idx    = r_idx;
        n_k      = r_k;
        n_cur    = r_cur;
        n_op     = r_op;
        n_req    = r_req;
        n_rel    = r_rel;
        n_res_st = r_res_st;
        n_res_gr = r_res_gr;
        n_ov     = r_ov && !i_m_axis_tready;
        n_odata  = r_odata;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_raddr  = r_idx;
        w_wdata  = r_cur;

        case (r_state)
            S_INIT: begin
                // first block spans the whole pool
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{offset: '0, length: LEN_W'(POOL_BYTES - HEADER_BYTES),
                            taken: 1'b0};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op    = t_op'(i_s_axis_tuser);
                    n_req   = i_s_axis_tdata[REQ_W-1:0];
                    n_rel   = i_s_axis_tdata[REQ_W+REL_W-1:REQ_W];
                    n_idx   = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                w_raddr = r_idx;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (r_op == OP_ALLOC && w_fit) begin
                    n_res_st = ST_OK;
                    n_res_gr = GNT_W'(w_data_off);
                    n_cur    = r_q;
                    if (w_split) begin
                        n_k = IDX_W'(r_count - CNT_W'(1));
                        n_state = w_more ? S_SHIFT_RD : S_INSERT;
                    end else begin
                        // remainder too small or table full: whole block goes
                        w_we    = 1'b1;
                        w_waddr = r_idx;
                        w_wdata = '{offset: r_q.offset, length: r_q.length,
                                    taken: 1'b1};
                        n_state = S_RESULT;
                    end
                end else if (r_op == OP_FREE && w_hit_off) begin
                    if (!r_q.taken) begin
                        n_res_st = ST_ALREADY_FREE;
                        n_res_gr = '0;
                        n_state  = S_RESULT;
                    end else begin
                        n_res_st = ST_OK;
                        n_res_gr = '0;
                        n_cur    = '{offset: r_q.offset, length: r_q.length,
                                     taken: 1'b0};
                        n_state  = S_CHK_NX;
                    end
                end else if (w_more) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_res_st = (r_op == OP_ALLOC) ? ST_NO_SPACE : ST_INVALID;
                    n_res_gr = '0;
                    n_state  = S_RESULT;
                end
            end
            // open a slot after the hit: move entries up, last one first
            S_SHIFT_RD: begin
                w_raddr = r_k;
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k + IDX_W'(1);
                w_wdata = r_q;
                if (r_k == r_idx + IDX_W'(1)) begin
                    n_state = S_INSERT;
                end else begin
                    n_k     = r_k - IDX_W'(1);
                    n_state = S_SHIFT_RD;
                end
            end
            S_INSERT: begin
                // free remainder right after the taken block
                w_we    = 1'b1;
                w_waddr = r_idx + IDX_W'(1);
                w_wdata = '{offset: OFF_W'(WIDE_W'(r_cur.offset) +
                                           WIDE_W'(HEADER_BYTES) + WIDE_W'(r_req)),
                            length: LEN_W'(WIDE_W'(r_cur.length) - WIDE_W'(r_req) -
                                           WIDE_W'(HEADER_BYTES)),
                            taken: 1'b0};
                n_count = r_count + CNT_W'(1);
                n_state = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = '{offset: r_cur.offset, length: LEN_W'(r_req), taken: 1'b1};
                n_state = S_RESULT;
            end
            // coalesce with the following block
            S_CHK_NX: begin
                if (w_more) begin
                    w_raddr = r_idx + IDX_W'(1);
                    n_state = S_NX_CK;
                end else begin
                    n_state = S_CHK_PV;
                end
            end
            S_NX_CK: begin
                if (!r_q.taken) begin
                    n_cur.length = LEN_W'(WIDE_W'(r_cur.length) + WIDE_W'(r_q.length) +
                                          WIDE_W'(HEADER_BYTES));
                    n_ret = S_CHK_NX;
                    // dropped entry is idx+1
                    if (CNT_W'(r_idx) + CNT_W'(2) == r_count) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_CHK_NX;
                    end else begin
                        n_k     = r_idx + IDX_W'(1);
                        n_state = S_DROP_RD;
                    end
                end else begin
                    n_state = S_CHK_PV;
                end
            end
            // coalesce with the preceding block
            S_CHK_PV: begin
                if (r_idx != '0) begin
                    w_raddr = r_idx - IDX_W'(1);
                    n_state = S_PV_CK;
                end else begin
                    n_state = S_FINAL_WR;
                end
            end
            S_PV_CK: begin
                if (!r_q.taken) begin
                    n_cur = '{offset: r_q.offset,
                              length: LEN_W'(WIDE_W'(r_cur.length) +
                                             WIDE_W'(r_q.length) +
                                             WIDE_W'(HEADER_BYTES)),
                              taken: 1'b0};
                    n_idx = r_idx - IDX_W'(1);
                    n_ret = S_CHK_PV;
                    // dropped entry is idx
                    if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_CHK_PV;
                    end else begin
                        n_k     = r_idx;
                        n_state = S_DROP_RD;
                    end
                end else begin
                    n_state = S_FINAL_WR;
                end
            end
            // close the gap at k: move later entries down, first one first
            S_DROP_RD: begin
                w_raddr = r_k + IDX_W'(1);
                n_state = S_DROP_WR;
            end
            S_DROP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = r_q;
                if (CNT_W'(r_k) + CNT_W'(2) == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = r_ret;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_DROP_RD;
                end
            end
            S_FINAL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_cur;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // load the output register once it is free
                if (!r_ov || i_m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = M_TDATA_W'({r_res_gr, r_res_st});
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_q <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_CHK_NX;
            r_count <= CNT_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_op     <= n_op;
        r_req    <= n_req;
        r_rel    <= n_rel;
        r_res_st <= n_res_st;
        r_res_gr <= n_res_gr;
        r_odata  <= n_odata;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

endmodule
